[rtl/core/bbc_pkg.sv]
// Package for the buffer cache block: sizes, op and status codes, and the
// controller-to-datapath command struct. No dependencies.
`timescale 1ns / 1ps
package bbc_pkg;
  localparam int NUM_BUFFERS = 32;
  localparam int COUNT_BITS  = 8;
  localparam int IDX_BITS    = $clog2(NUM_BUFFERS);

  localparam logic [1:0] OP_GET     = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_PIN     = 2'd2;
  localparam logic [1:0] OP_UNPIN   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_FREE   = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_SATURATED = 2'd3;

  typedef struct packed {
    logic capture;  // latch the request beat
    logic execute;  // apply the update and register the result
  } bbc_cmd_t;
endpackage

[rtl/core/bbc_ctrl.sv]
// Controller for the buffer cache: sequences capture and execute steps.
// Depends on bbc_pkg.
`timescale 1ns / 1ps
module bbc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  output logic             strobe,
  output bbc_pkg::bbc_cmd_t cmd
);
  import bbc_pkg::*;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_EXEC;
      S_EXEC: state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign busy        = (state != S_IDLE);
  assign strobe      = (state == S_DONE);
  assign cmd.capture = (state == S_IDLE) && start;
  assign cmd.execute = (state == S_EXEC);
endmodule

[rtl/core/bbc_datapath.sv]
// Datapath for the buffer cache: tags, counts, valid marks, recency order,
// parallel lookup and update. Depends on bbc_pkg.
`timescale 1ns / 1ps
module bbc_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  bbc_pkg::bbc_cmd_t           cmd,
  input  logic [1:0]                  op,
  input  logic [7:0]                  device,
  input  logic [31:0]                 block_number,
  input  logic [4:0]                  buffer_slot,
  output logic [4:0]                  slot_out,
  output logic                        was_hit,
  output logic                        needs_fill,
  output logic [1:0]                  status
);
  import bbc_pkg::*;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic [7:0]            tag_device [NUM_BUFFERS];
  logic [31:0]           tag_block  [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] entry_valid;
  logic [COUNT_BITS-1:0] ref_count  [NUM_BUFFERS];
  // rank of each entry in the recency order: 0 is most recent.
  logic [IDX_BITS-1:0]   rank       [NUM_BUFFERS];

  logic [1:0]  req_op;
  logic [7:0]  req_dev;
  logic [31:0] req_blk;
  logic [4:0]  req_slot;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_op   <= op;
      req_dev  <= device;
      req_blk  <= block_number;
      req_slot <= buffer_slot;
    end
  end

  // Match and free vectors, then a pick by rank: distinct ranks make the
  // lowest-rank match and highest-rank free entry unique.
  logic [NUM_BUFFERS-1:0] match, free_e;
  logic [NUM_BUFFERS-1:0] match_by_rank, free_by_rank;
  always_comb begin
    match_by_rank = '0;
    free_by_rank  = '0;
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      match[i]  = (tag_device[i] == req_dev) && (tag_block[i] == req_blk);
      free_e[i] = (ref_count[i] == '0);
      if (match[i])  match_by_rank[rank[i]] = 1'b1;
      if (free_e[i]) free_by_rank[rank[i]]  = 1'b1;
    end
  end

  logic                hit_f, free_f;
  logic [IDX_BITS-1:0] hit_rank, free_rank;
  always_comb begin
    hit_f = 1'b0; hit_rank = '0;
    free_f = 1'b0; free_rank = '0;
    for (int r = NUM_BUFFERS - 1; r >= 0; r--) begin
      if (match_by_rank[r]) begin
        hit_f = 1'b1; hit_rank = IDX_BITS'(r);
      end
    end
    for (int r = 0; r < NUM_BUFFERS; r++) begin
      if (free_by_rank[r]) begin
        free_f = 1'b1; free_rank = IDX_BITS'(r);
      end
    end
  end

  logic [IDX_BITS-1:0] hit_e, free_idx;
  always_comb begin
    hit_e = '0; free_idx = '0;
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      if (match[i] && rank[i] == hit_rank) hit_e = IDX_BITS'(i);
      if (free_e[i] && rank[i] == free_rank) free_idx = IDX_BITS'(i);
    end
  end

  logic                slot_ok;
  logic [IDX_BITS-1:0] sidx;
  logic [COUNT_BITS-1:0] scount;
  assign slot_ok = (32'(req_slot) < 32'(NUM_BUFFERS));
  assign sidx    = IDX_BITS'(req_slot);
  assign scount  = ref_count[sidx];

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        tag_device[i] <= '0;
        tag_block[i]  <= '0;
        ref_count[i]  <= '0;
        rank[i]       <= IDX_BITS'(NUM_BUFFERS - 1 - i);
      end
    end else if (cmd.execute) begin
      was_hit    <= 1'b0;
      needs_fill <= 1'b0;
      status     <= ST_OK;
      slot_out   <= req_slot;
      if (req_op == OP_GET) begin
        if (hit_f) begin
          was_hit    <= 1'b1;
          slot_out   <= 5'(hit_e);
          needs_fill <= !entry_valid[hit_e];
          entry_valid[hit_e] <= 1'b1;
          if (ref_count[hit_e] == CMAX) status <= ST_SATURATED;
          else ref_count[hit_e] <= ref_count[hit_e] + 1'b1;
        end else if (free_f) begin
          slot_out   <= 5'(free_idx);
          needs_fill <= 1'b1;
          entry_valid[free_idx] <= 1'b1;
          tag_device[free_idx]  <= req_dev;
          tag_block[free_idx]   <= req_blk;
          ref_count[free_idx]   <= COUNT_BITS'(1);
        end else begin
          slot_out <= '0;
          status   <= ST_NO_FREE;
        end
      end else if (slot_ok) begin
        if (req_op == OP_PIN) begin
          if (scount == CMAX) status <= ST_SATURATED;
          else ref_count[sidx] <= scount + 1'b1;
        end else if (scount == '0) begin
          status <= ST_UNDERFLOW;
        end else begin
          ref_count[sidx] <= scount - 1'b1;
          if (req_op == OP_RELEASE && scount == COUNT_BITS'(1)) begin
            for (int i = 0; i < NUM_BUFFERS; i++) begin
              if (i == int'(sidx)) rank[i] <= '0;
              else if (rank[i] < rank[sidx]) rank[i] <= rank[i] + 1'b1;
            end
          end
        end
      end
    end
  end
endmodule

[rtl/core/block_buffer_cache_lru.sv]
// Top level of the buffer cache tag store: controller plus datapath.
// Depends on bbc_pkg, bbc_ctrl and bbc_datapath.
//
// Channel   Direction  Handshake                Payload
// request   in         start && !busy           op, device, block_number, buffer_slot
// result    out        strobe (one cycle)       slot_out, was_hit, needs_fill, status
//
// After its accepting edge, each request passes through the execute state, which
// does the parallel tag compare, pick and update and registers the result, and
// then the done state, which presents the result with strobe high. The controller
// then returns to idle, and only there is the next request accepted, so requests
// never overlap. Reset (rst, synchronous) clears all tags, counts and valid marks
// and restores the recency order. The receiver cannot stall.
`timescale 1ns / 1ps
module block_buffer_cache_lru (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [7:0]  device,
  input  logic [31:0] block_number,
  input  logic [4:0]  buffer_slot,
  output logic        strobe,
  output logic [4:0]  slot_out,
  output logic        was_hit,
  output logic        needs_fill,
  output logic [1:0]  status
);
  import bbc_pkg::*;
  bbc_cmd_t cmd;

  // The controller paces the request; the datapath holds all tag store state.
  bbc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .strobe(strobe), .cmd(cmd)
  );

  bbc_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .op(op), .device(device),
    .block_number(block_number), .buffer_slot(buffer_slot),
    .slot_out(slot_out), .was_hit(was_hit), .needs_fill(needs_fill), .status(status)
  );
endmodule

[rtl/core/bbc_checker.sv]
// Port-level checker for the buffer cache, bound to the top level.
// Depends on bbc_pkg.
`timescale 1ns / 1ps
module bbc_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       strobe,
  input logic       was_hit,
  input logic       needs_fill,
  input logic [1:0] status
);
  import bbc_pkg::*;
  a_strobe_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 strobe) else $error("missing result strobe");
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe) else $error("strobe held");
  a_busy_on_strobe: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy) else $error("strobe while idle");
  a_no_free_clean: assert property (@(posedge clk) disable iff (rst)
    (strobe && status == ST_NO_FREE) |-> (!was_hit && !needs_fill))
    else $error("no-free result carries hit or fill");
endmodule

bind block_buffer_cache_lru bbc_checker u_bbc_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .strobe(strobe),
  .was_hit(was_hit), .needs_fill(needs_fill), .status(status)
);

[dv/block_buffer_cache_lru_test.sv]
// Self-checking testbench for the buffer cache tag store block_buffer_cache_lru.
// Depends on bbc_pkg and the RTL; a scoreboard class predicts each result beat.
`timescale 1ns / 1ps

// Scoreboard: a private copy of the tag store that predicts the result of every
// accepted request beat and checks result beats against the queue in order.
class bbc_scoreboard;
  logic [7:0]  dev_tag [bbc_pkg::NUM_BUFFERS];
  logic [31:0] blk_tag [bbc_pkg::NUM_BUFFERS];
  bit          valid_mark [bbc_pkg::NUM_BUFFERS];
  int unsigned refs [bbc_pkg::NUM_BUFFERS];
  int unsigned lru_list [bbc_pkg::NUM_BUFFERS];
  logic [8:0]  pending [$];
  int          mismatches;

  function void clear();
    for (int i = 0; i < bbc_pkg::NUM_BUFFERS; i++) begin
      dev_tag[i] = '0;
      blk_tag[i] = '0;
      valid_mark[i] = 0;
      refs[i] = 0;
      lru_list[i] = bbc_pkg::NUM_BUFFERS - 1 - i;
    end
    pending.delete();
    mismatches = 0;
  endfunction

  // Moves an entry to the most recent position of the recency list.
  function void promote(int unsigned entry);
    int p;
    p = 0;
    while (p < bbc_pkg::NUM_BUFFERS && lru_list[p] != entry) p++;
    for (int i = p; i > 0; i--) lru_list[i] = lru_list[i-1];
    lru_list[0] = entry;
  endfunction

  // Applies one request to the copy and queues {slot, hit, fill, status}.
  function void note_request(logic [1:0] op, logic [7:0] dev, logic [31:0] blk,
                             logic [4:0] slot);
    int unsigned cmax, e;
    logic [4:0] rslot;
    bit hit, fill, found;
    logic [1:0] st;
    cmax = (1 << bbc_pkg::COUNT_BITS) - 1;
    rslot = slot;
    hit = 0;
    fill = 0;
    found = 0;
    e = 0;
    st = bbc_pkg::ST_OK;
    if (op == bbc_pkg::OP_GET) begin
      for (int i = 0; i < bbc_pkg::NUM_BUFFERS && !found; i++)
        if (dev_tag[lru_list[i]] == dev && blk_tag[lru_list[i]] == blk) begin
          found = 1;
          e = lru_list[i];
        end
      if (found) begin
        hit = 1;
        if (refs[e] >= cmax) st = bbc_pkg::ST_SATURATED;
        else refs[e]++;
      end else begin
        for (int i = bbc_pkg::NUM_BUFFERS - 1; i >= 0 && !found; i--)
          if (refs[lru_list[i]] == 0) begin
            found = 1;
            e = lru_list[i];
          end
        if (found) begin
          dev_tag[e] = dev;
          blk_tag[e] = blk;
          valid_mark[e] = 0;
          refs[e] = 1;
        end
      end
      if (found) begin
        rslot = e[4:0];
        fill = !valid_mark[e];
        valid_mark[e] = 1;
      end else begin
        rslot = '0;
        st = bbc_pkg::ST_NO_FREE;
      end
    end else if (slot < bbc_pkg::NUM_BUFFERS) begin
      if (op == bbc_pkg::OP_PIN) begin
        if (refs[slot] >= cmax) st = bbc_pkg::ST_SATURATED;
        else refs[slot]++;
      end else if (refs[slot] == 0) begin
        st = bbc_pkg::ST_UNDERFLOW;
      end else begin
        refs[slot]--;
        if (op == bbc_pkg::OP_RELEASE && refs[slot] == 0) promote(slot);
      end
    end
    pending.push_back({rslot, hit, fill, st});
  endfunction

  function void check_result(logic [4:0] slot, logic hit, logic fill, logic [1:0] st);
    logic [8:0] want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat slot=%0d", slot);
      return;
    end
    want = pending.pop_front();
    if (want !== {slot, hit, fill, st}) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected slot=%0d hit=%0d fill=%0d status=%0d, got %0d %0d %0d %0d",
                 want[8:4], want[3], want[2], want[1:0], slot, hit, fill, st);
    end
  endfunction
endclass

module block_buffer_cache_lru_test;
  import bbc_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [1:0]  op = OP_GET;
  logic [7:0]  device = '0;
  logic [31:0] block_number = '0;
  logic [4:0]  buffer_slot = '0;
  logic        strobe;
  logic [4:0]  slot_out;
  logic        was_hit;
  logic        needs_fill;
  logic [1:0]  status;

  bbc_scoreboard board;
  int unsigned cycles = 0;
  // Small pool of block tags so that gets hit often and entries recycle.
  logic [31:0] blk_pool [8];
  logic [7:0]  dev_pool [4];
  int          held_slots [$];

  block_buffer_cache_lru dut (.*);

  always #5 clk = ~clk;

  // Result beats can't be held off, so every strobe is checked at the edge.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && strobe) board.check_result(slot_out, was_hit, needs_fill, status);
  end

  // Timeout bound covers every request beat plus its random idle gap.
  always @(posedge clk)
    if (cycles > 200000) begin
      $display("tb: failure");
      $finish;
    end

  // Sends one request beat: present at the falling edge, wait for acceptance,
  // then note it with the scoreboard. With no gap, start simply stays high and
  // the next beat is taken once the block is idle again.
  task automatic send_request(logic [1:0] o, logic [7:0] d, logic [31:0] b, logic [4:0] s);
    int gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) start <= 0;
    repeat (gap) @(negedge clk);
    op <= o;
    device <= d;
    block_number <= b;
    buffer_slot <= s;
    start <= 1;
    do @(posedge clk); while (busy);
    board.note_request(o, d, b, s);
    @(negedge clk);
  endtask

  // Random get from the pools, remembering returned slots for later releases.
  task automatic random_get();
    send_request(OP_GET, dev_pool[$urandom_range(0, 3)], blk_pool[$urandom_range(0, 7)],
                 5'($urandom));
    held_slots.push_back(board.pending[board.pending.size()-1][8:4]);
  endtask

  initial begin
    int pick;
    board = new();
    board.clear();
    for (int i = 0; i < 8; i++) blk_pool[i] = $urandom;
    blk_pool[0] = '0;
    blk_pool[1] = '1;
    for (int i = 0; i < 4; i++) dev_pool[i] = 8'($urandom);
    dev_pool[0] = '0;
    dev_pool[1] = '1;
    repeat (12) @(negedge clk);
    rst <= 0;

    // Directed part: initial tag hit, extremes, all ops, underflow.
    send_request(OP_GET, 8'h00, 32'h0, 5'd0);
    send_request(OP_GET, 8'hff, 32'hffff_ffff, 5'd31);
    send_request(OP_GET, 8'hff, 32'hffff_ffff, 5'd0);
    send_request(OP_UNPIN, 8'h0, 32'h0, 5'd0);
    send_request(OP_RELEASE, 8'h0, 32'h0, 5'd3);
    send_request(OP_PIN, 8'h0, 32'h0, 5'd31);
    send_request(OP_UNPIN, 8'h0, 32'h0, 5'd31);
    send_request(OP_RELEASE, 8'h0, 32'h0, 5'd31);
    send_request(OP_RELEASE, 8'h0, 32'h0, 5'd30);
    send_request(OP_RELEASE, 8'h0, 32'h0, 5'd30);
    send_request(OP_GET, 8'h5a, 32'h1234_5678, 5'd7);
    // Drive entry 3 to saturation and beyond with pins, repeat an earlier get, then unpin it to underflow.
    repeat (257) send_request(OP_PIN, 8'h0, 32'h0, 5'd3);
    send_request(OP_GET, 8'h5a, 32'h1234_5678, 5'd0);
    repeat (256) send_request(OP_UNPIN, 8'h0, 32'h0, 5'd3);
    // Fill every entry so that a further miss finds nothing free.
    for (int i = 0; i < 33; i++) send_request(OP_GET, 8'h77, 32'(i + 100), 5'd0);
    for (int i = 0; i < 32; i++) begin
      send_request(OP_RELEASE, 8'h0, 32'h0, 5'(i));
      send_request(OP_RELEASE, 8'h0, 32'h0, 5'(i));
    end

    // Random part: mostly balanced get/release traffic, some noise.
    repeat (680) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) random_get();
      else if (pick < 80 && held_slots.size() > 0)
        send_request(OP_RELEASE, 8'($urandom), $urandom,
                     5'(held_slots[$urandom_range(0, held_slots.size()-1)]));
      else if (pick < 90)
        send_request(OP_PIN, 8'($urandom), $urandom, 5'($urandom));
      else
        send_request(pick[0] ? OP_UNPIN : OP_RELEASE, 8'($urandom), $urandom, 5'($urandom));
      if (held_slots.size() > 64) void'(held_slots.pop_front());
    end
    start <= 0;

    while (board.pending.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

[files.f]
rtl/core/bbc_pkg.sv
rtl/core/bbc_ctrl.sv
rtl/core/bbc_datapath.sv
rtl/core/block_buffer_cache_lru.sv
rtl/core/bbc_checker.sv
dv/block_buffer_cache_lru_test.sv
